// File: hw/rtl/task_oncpu_time_window_accumulator_unit_assert.svh
// Assertion macros for the task on-CPU time window accumulator.
// Used by the top level; expects clk and arst_n in scope at the point of use.
`ifndef TASK_ONCPU_TIME_WINDOW_ACCUMULATOR_UNIT_ASSERT_SVH
`define TASK_ONCPU_TIME_WINDOW_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TOWA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TOWA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/towa_pkg.sv
// Shared constants, types and controller/datapath command structs
// for the task on-CPU time window accumulator. No dependencies.
`default_nettype none

package towa_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam int TS_W    = 64;
	localparam int ID_W    = 22;
	localparam int LEN_W   = 40;
	localparam int TOTAL_W = 64;

	localparam int NS_PER_US = 1000;
	localparam int REM_W     = $clog2(NS_PER_US);

	// digit divide: quotient digit = (part * DIV_RECIP) >> DIV_SHIFT, exact for parts below 2^26
	localparam int DIV_CHUNK_W = 16;
	localparam int DIV_STEPS   = TS_W / DIV_CHUNK_W;
	localparam int DIV_CNT_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int DIV_PART_W  = REM_W + DIV_CHUNK_W;
	localparam int DIV_SHIFT   = 36;
	localparam int DIV_RECIP_W = 27;
	localparam int DIV_PROD_W  = DIV_PART_W + DIV_RECIP_W;
	localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(68719477);

	localparam logic [ID_W-1:0]  TARGET_RST = ID_W'(30058);
	localparam logic [LEN_W-1:0] WLEN_RST   = LEN_W'(64'd1000000000);

	localparam int APB_AW = 4;
	localparam int APB_DW = 64;

	typedef enum logic {
		REG_TARGET_GROUP = 1'b0,
		REG_WINDOW_LEN   = 1'b1
	} towa_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PMATCH,
		ST_PREAD,
		ST_PSUB,
		ST_PCHK,
		ST_DIV,
		ST_ADD,
		ST_WIN,
		ST_WCMP,
		ST_NMATCH,
		ST_NWRITE
	} towa_state_t;

	typedef struct packed {
		logic load;
		logic match_prev;
		logic match_next;
		logic read;
		logic sub;
		logic div_start;
		logic add;
		logic win;
		logic emit;
		logic update;
	} towa_cmd_t;

	typedef struct packed {
		logic acc_ok;
		logic div_done;
		logic win_due;
		logic out_busy;
	} towa_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/towa_div.sv
// Unsigned divide of a timestamp difference by NS_PER_US: long division in
// 16-bit digits, each digit by reciprocal multiplication then a retire step; depends on towa_pkg.
`default_nettype none

module towa_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [towa_pkg::TS_W-1:0] dividend,
	output logic      [towa_pkg::TS_W-1:0] quotient,
	output logic                          done
);
	import towa_pkg::*;

	logic [TS_W-1:0]        dvd_q;
	logic [TS_W-1:0]        quo_q;
	logic [REM_W-1:0]       rem_q;
	logic [DIV_PROD_W-1:0]  prod_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   phase_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DIV_PART_W-1:0]  part;
	logic [DIV_CHUNK_W-1:0] qdig;
	logic [REM_W-1:0]       rem_nxt;

	always_comb begin
		part    = {rem_q, dvd_q[TS_W-1 -: DIV_CHUNK_W]};
		qdig    = prod_q[DIV_SHIFT +: DIV_CHUNK_W];
		rem_nxt = REM_W'(part - DIV_PART_W'(qdig) * DIV_PART_W'(NS_PER_US));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (busy_q) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// multiply in the first phase of a digit, retire the digit in the second
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				prod_q <= DIV_PROD_W'(part) * DIV_PROD_W'(DIV_RECIP);
			end else begin
				dvd_q <= dvd_q << DIV_CHUNK_W;
				quo_q <= {quo_q[TS_W-DIV_CHUNK_W-1:0], qdig};
				rem_q <= rem_nxt;
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

// File: hw/rtl/towa_ctrl.sv
// Sequencing state machine: walks one context-switch transaction through
// lookup, accumulate, window check and table update. Depends on towa_pkg.
`default_nettype none

module towa_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire towa_pkg::towa_sts_t  sts,
	output towa_pkg::towa_cmd_t       cmd
);
	import towa_pkg::*;

	towa_state_t state_q;
	towa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_PMATCH;
			end
			ST_PMATCH: state_d = ST_PREAD;
			ST_PREAD:  state_d = ST_PSUB;
			ST_PSUB:   state_d = ST_PCHK;
			ST_PCHK: begin
				state_d = sts.acc_ok ? ST_DIV : ST_WIN;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_ADD;
			end
			ST_ADD: state_d = ST_WIN;
			ST_WIN: state_d = ST_WCMP;
			ST_WCMP: begin
				// hold while a due result cannot be placed in the output register
				if (!(sts.win_due && sts.out_busy)) state_d = ST_NMATCH;
			end
			ST_NMATCH: state_d = ST_NWRITE;
			ST_NWRITE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			ST_PMATCH: cmd.match_prev = 1'b1;
			ST_PREAD:  cmd.read       = 1'b1;
			ST_PSUB:   cmd.sub        = 1'b1;
			ST_PCHK:   cmd.div_start  = sts.acc_ok;
			ST_ADD:    cmd.add        = 1'b1;
			ST_WIN:    cmd.win        = 1'b1;
			ST_WCMP:   cmd.emit       = sts.win_due && !sts.out_busy;
			ST_NMATCH: cmd.match_next = 1'b1;
			ST_NWRITE: cmd.update     = 1'b1;
			default: begin
				cmd        = '0;
				item_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/towa_dp.sv
// Datapath: input registers, task tag table with start-time memory,
// running total, window timing and the result register. Uses towa_pkg, towa_div.
`default_nettype none

module towa_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire towa_pkg::towa_cmd_t        cmd,
	output towa_pkg::towa_sts_t             sts,
	input  wire logic [towa_pkg::ID_W-1:0]  target_group_id,
	input  wire logic [towa_pkg::LEN_W-1:0] window_length_ns,
	input  wire logic [towa_pkg::TS_W-1:0]  timestamp_ns,
	input  wire logic                       prev_running,
	input  wire logic [towa_pkg::ID_W-1:0]  prev_task_id,
	input  wire logic [towa_pkg::ID_W-1:0]  prev_group_id,
	input  wire logic [towa_pkg::ID_W-1:0]  next_task_id,
	input  wire logic [towa_pkg::ID_W-1:0]  next_group_id,
	output logic                            result_valid,
	input  wire logic                       result_ready,
	output logic [towa_pkg::TOTAL_W-1:0]    window_total_us
);
	import towa_pkg::*;

	// latched transaction
	logic [TS_W-1:0] now_q;
	logic            run_q;
	logic [ID_W-1:0] ptask_q;
	logic [ID_W-1:0] pgroup_q;
	logic [ID_W-1:0] ntask_q;
	logic [ID_W-1:0] ngroup_q;

	// task table: tags compared in parallel, start times in a memory
	logic [ID_W-1:0]          slot_task_q [TABLE_ENTRIES];
	logic [TS_W-1:0]          start_mem   [TABLE_ENTRIES];
	logic [CNT_W-1:0]         fill_q;
	logic [TABLE_ENTRIES-1:0] match_d;
	logic [TABLE_ENTRIES-1:0] match_q;
	logic [ID_W-1:0]          tag;
	logic [SLOT_W-1:0]        hit_idx;
	logic                     hit;
	logic [TS_W-1:0]          start_rd_q;
	logic [SLOT_W-1:0]        fill_idx;
	logic                     has_room;
	logic                     upd_ok;
	logic                     mem_we;
	logic                     new_we;
	logic [SLOT_W-1:0]        mem_waddr;

	// accounting
	logic [TS_W-1:0]    diff_q;
	logic               acc_ok_q;
	logic [TS_W-1:0]    quot;
	logic               div_done;
	logic [TOTAL_W-1:0] total_q;
	logic [TS_W-1:0]    wstart_q;
	logic               started_q;
	logic [TS_W-1:0]    wdiff_q;
	logic [TOTAL_W-1:0] out_q;
	logic               out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q    <= timestamp_ns;
			run_q    <= prev_running;
			ptask_q  <= prev_task_id;
			pgroup_q <= prev_group_id;
			ntask_q  <= next_task_id;
			ngroup_q <= next_group_id;
		end
	end

	// valid entries form a prefix of the table since entries are never removed
	always_comb begin
		tag = cmd.match_next ? ntask_q : ptask_q;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match_d[i] = (CNT_W'(i) < fill_q) && (slot_task_q[i] == tag);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match_prev || cmd.match_next) begin
			match_q <= match_d;
		end
	end

	// ids are unique among valid entries, so the match vector is at most one-hot
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (match_q[i]) hit_idx = hit_idx | SLOT_W'(i);
		end
		hit = |match_q;
	end

	always_comb begin
		fill_idx  = fill_q[SLOT_W-1:0];
		has_room  = (fill_q < CNT_W'(TABLE_ENTRIES));
		upd_ok    = cmd.update && (ngroup_q == target_group_id);
		mem_we    = upd_ok && (hit || has_room);
		new_we    = upd_ok && !hit && has_room;
		mem_waddr = hit ? hit_idx : fill_idx;
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			start_rd_q <= start_mem[hit_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			start_mem[mem_waddr] <= now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (new_we) begin
			slot_task_q[fill_idx] <= ntask_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (new_we) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sub) begin
			diff_q <= now_q - start_rd_q;
		end
	end

	towa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (diff_q),
		.quotient (quot),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.win) begin
			wdiff_q <= started_q ? (now_q - wstart_q) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_ok_q    <= 1'b0;
			total_q     <= '0;
			wstart_q    <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sub) begin
				acc_ok_q <= run_q && started_q && (pgroup_q == target_group_id) && hit
					&& (now_q >= start_rd_q);
			end
			if (cmd.add) begin
				total_q <= total_q + quot;
			end
			if (cmd.win && !started_q) begin
				started_q <= 1'b1;
				wstart_q  <= now_q;
			end
			if (cmd.emit) begin
				total_q  <= '0;
				wstart_q <= now_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.acc_ok   = acc_ok_q;
		sts.div_done = div_done;
		sts.win_due  = (wdiff_q >= {{(TS_W-LEN_W){1'b0}}, window_length_ns});
		sts.out_busy = out_valid_q;
	end

	assign result_valid    = out_valid_q;
	assign window_total_us = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/task_oncpu_time_window_accumulator_unit.sv
// Per-task on-CPU time accumulator. Each transaction on the item channel is one
// context switch; the block looks the outgoing task up in a 64-entry task table,
// adds its elapsed run time in microseconds to a running total, and delivers the
// total on the result channel whenever the configured window has elapsed, then
// records the incoming task's switch-in time. Items are handled one at a time:
// each accepted transaction runs through lookup, accumulate, window check and
// table update before the next is taken; the divide by 1000 runs four
// 16-bit digits as a multiply and a retire step. A due result waits for the
// output register to empty, stretching that item while the result channel stalls.
// The output register lets a new item be taken while a result is pending.
// Registers: target_group_id at 0x0, window_length_ns at 0x8 (APB, 64-bit data).
`default_nettype none

`include "task_oncpu_time_window_accumulator_unit_assert.svh"

module task_oncpu_time_window_accumulator_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [towa_pkg::APB_AW-1:0]  paddr,
	input  wire logic [towa_pkg::APB_DW-1:0]  pwdata,
	output logic      [towa_pkg::APB_DW-1:0]  prdata,
	output logic                              pready,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic [towa_pkg::TS_W-1:0]    timestamp_ns,
	input  wire logic                         prev_running,
	input  wire logic [towa_pkg::ID_W-1:0]    prev_task_id,
	input  wire logic [towa_pkg::ID_W-1:0]    prev_group_id,
	input  wire logic [towa_pkg::ID_W-1:0]    next_task_id,
	input  wire logic [towa_pkg::ID_W-1:0]    next_group_id,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic      [towa_pkg::TOTAL_W-1:0] window_total_us
);
	import towa_pkg::*;

	logic [ID_W-1:0]  target_q;
	logic [LEN_W-1:0] wlen_q;
	logic             cfg_wr;
	towa_reg_t        reg_sel;
	towa_cmd_t        cmd;
	towa_sts_t        sts;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = towa_reg_t'(paddr[APB_AW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			wlen_q   <= WLEN_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_TARGET_GROUP: target_q <= pwdata[ID_W-1:0];
				REG_WINDOW_LEN:   wlen_q   <= pwdata[LEN_W-1:0];
				default:          target_q <= target_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_TARGET_GROUP: prdata = APB_DW'(target_q);
			REG_WINDOW_LEN:   prdata = APB_DW'(wlen_q);
			default:          prdata = '0;
		endcase
	end

	towa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	towa_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.target_group_id  (target_q),
		.window_length_ns (wlen_q),
		.timestamp_ns     (timestamp_ns),
		.prev_running     (prev_running),
		.prev_task_id     (prev_task_id),
		.prev_group_id    (prev_group_id),
		.next_task_id     (next_task_id),
		.next_group_id    (next_group_id),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.window_total_us  (window_total_us)
	);

	`TOWA_ASSERT_NOW(a_emit_free, cmd.emit, !sts.out_busy, "result overwritten while pending")
	`TOWA_ASSERT_NOW(a_add_done, cmd.add, sts.div_done, "total updated before divide finished")
	`TOWA_ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready, "second item taken while busy")
	`TOWA_ASSERT_NEXT(a_emit_shows, cmd.emit, result_valid, "emitted total not presented")

endmodule

`default_nettype wire
